>>> design/assert_macros.svh
// Assertion helpers shared by the extractor modules.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DRA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/dra_pkg.sv
// Shared types and constants for the DNS reply answer extractor.
// No dependencies; imported by dra_front, dra_back and the top level.
`timescale 1ns / 1ps

package dra_pkg;

  localparam int HDR_BYTES   = 12;
  localparam int FIXED_BYTES = 10;
  localparam int MAX_LABEL   = 63;
  localparam int QTAIL_BYTES = 4;
  localparam int V4_BYTES    = 4;
  localparam int V6_BYTES    = 16;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] TYPE_PTR  = 16'd12;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [2:0] KIND_V4    = 3'd0;
  localparam logic [2:0] KIND_V6    = 3'd1;
  localparam logic [2:0] KIND_CHAR  = 3'd2;
  localparam logic [2:0] KIND_NONE  = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QLABEL,
    PH_QPTR,
    PH_QTAIL,
    PH_ANAME,
    PH_ALABEL,
    PH_APTR,
    PH_AFIXED,
    PH_ASKIP,
    PH_ADDR,
    PH_PNAME,
    PH_PLABEL,
    PH_PPTR,
    PH_DONE
  } phase_t;

  // One message byte as it leaves the front end, already classified.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_ptr;
  } msg_beat_t;

endpackage

>>> design/dns_reply_answer_extractor.sv
// DNS reply answer extractor, top level.
//
// Input channel: one message byte per beat on in_msg_byte, with in_msg_end
// high on the final byte. Result channel: zero or one result beat per byte,
// carrying the query id, the kind (IPv4 byte, IPv6 byte, name character,
// none found, truncated), a payload byte, and a final mark on the last beat
// of each message. Both channels use valid/ready.
//
// Throughput: one byte per cycle while the result side is not stalled. The
// front end queues up to four bytes, so a stalled result side fills the
// queue before in_ready drops. Each byte passes a queue slot and then the
// output register on its way to a result beat on the outputs.
// While a result beat waits with out_ready low, the result register holds and
// the parser stops taking bytes; the queue absorbs input meanwhile.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and sets the parser to the header; no clearing pass follows. After each
// final-marked byte the parser rearms itself for the next message.
// Depends on dra_pkg, dra_front and dra_back.
`timescale 1ns / 1ps

module dns_reply_answer_extractor
  import dra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_msg_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_query_tag,
  output logic [2:0]  out_answer_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_final_result
);

  logic      q_valid;
  logic      q_pop;
  msg_beat_t q_beat;

  dra_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_msg_byte (in_msg_byte),
    .in_msg_end  (in_msg_end),
    .q_valid     (q_valid),
    .q_beat      (q_beat),
    .q_pop       (q_pop)
  );

  dra_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_beat           (q_beat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_query_tag    (out_query_tag),
    .out_answer_kind  (out_answer_kind),
    .out_payload_byte (out_payload_byte),
    .out_final_result (out_final_result)
  );

endmodule

>>> design/dra_front.sv
// Front end: accepts message bytes, tags each one as name end, pointer or
// plain byte, and holds them in a short queue for the parser. Uses dra_pkg.
`timescale 1ns / 1ps

module dra_front
  import dra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_msg_byte,
  input  logic       in_msg_end,
  output logic       q_valid,
  output msg_beat_t  q_beat,
  input  logic       q_pop
);

  msg_beat_t               slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_r;
  logic [QUEUE_AW-1:0]     rd_ptr_r;
  logic [QUEUE_AW:0]       count_r;
  logic                    push;
  logic                    pop;
  msg_beat_t               new_beat;

  assign in_ready = (count_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_beat   = slot_r[rd_ptr_r];

  always_comb begin
    new_beat.data    = in_msg_byte;
    new_beat.last    = in_msg_end;
    new_beat.is_zero = (in_msg_byte == 8'd0);
    new_beat.is_ptr  = (in_msg_byte > 8'(MAX_LABEL));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`include "assert_macros.svh"
  `DRA_NEVER(a_q_overfill, count_r > (QUEUE_AW + 1)'(QUEUE_DEPTH), "queue count above depth")
  `DRA_ASSERT(a_q_count_step, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue count missed a push")

endmodule

>>> design/dra_back.sv
// Back end: walks the DNS message one byte per cycle when not stalled and
// registers at most one result beat per byte. Uses dra_pkg, assert_macros.svh.
`timescale 1ns / 1ps

module dra_back
  import dra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  msg_beat_t   q_beat,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_query_tag,
  output logic [2:0]  out_answer_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_final_result
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] ans_r, ans_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] body_r, body_nxt;
  logic [5:0]  label_r, label_nxt;
  logic [7:0]  held_char_r, held_char_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        started_r, started_nxt;
  logic        done_r, done_nxt;

  logic        out_valid_r;
  logic [15:0] out_tag_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_fin_r;

  logic        advance;
  logic        emit;
  logic [2:0]  emit_kind;
  logic [7:0]  emit_byte;
  logic        emit_fin;
  logic [15:0] emit_tag;
  logic        do_skip;
  logic        do_rec_done;
  logic        rev_end;
  logic [7:0]  b;

  // Take a byte whenever the output slot is free or drains this cycle.
  assign advance = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = advance;
  assign b       = q_beat.data;

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    tag_nxt        = tag_r;
    ans_nxt        = ans_r;
    rtype_nxt      = rtype_r;
    body_nxt       = body_r;
    label_nxt      = label_r;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    started_nxt    = started_r;
    done_nxt       = done_r;
    emit           = 1'b0;
    emit_kind      = KIND_NONE;
    emit_byte      = 8'd0;
    emit_fin       = 1'b0;
    emit_tag       = tag_r;
    do_skip        = 1'b0;
    do_rec_done    = 1'b0;
    rev_end        = 1'b0;

    if (advance) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r == 16'd0) tag_nxt = {b, 8'd0};
          else if (cnt_r == 16'd1) tag_nxt = tag_r | {8'd0, b};
          else if (cnt_r == 16'd6) ans_nxt = {b, 8'd0};
          else if (cnt_r == 16'd7) ans_nxt = ans_r | {8'd0, b};
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_r >= 16'(HDR_BYTES - 1)) begin
            cnt_nxt   = 16'd0;
            phase_nxt = PH_QNAME;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (q_beat.is_zero) begin
            cnt_nxt   = 16'd0;
            phase_nxt = (phase_r == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
          end else if (q_beat.is_ptr) begin
            phase_nxt = (phase_r == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else begin
            label_nxt = b[5:0];
            phase_nxt = (phase_r == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
          end
        end
        PH_QLABEL, PH_ALABEL: begin
          label_nxt = label_r - 6'd1;
          if (label_nxt == 6'd0) begin
            phase_nxt = (phase_r == PH_QLABEL) ? PH_QNAME : PH_ANAME;
          end
        end
        PH_QPTR: begin
          cnt_nxt   = 16'd0;
          phase_nxt = PH_QTAIL;
        end
        PH_APTR: begin
          cnt_nxt   = 16'd0;
          phase_nxt = PH_AFIXED;
        end
        PH_QTAIL: begin
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_nxt >= 16'(QTAIL_BYTES)) begin
            if (ans_r == 16'd0) begin
              emit      = 1'b1;
              emit_kind = KIND_NONE;
              emit_fin  = 1'b1;
            end else begin
              phase_nxt = PH_ANAME;
            end
          end
        end
        PH_AFIXED: begin
          if (cnt_r == 16'd0) rtype_nxt = {b, 8'd0};
          else if (cnt_r == 16'd1) rtype_nxt = rtype_r | {8'd0, b};
          else if (cnt_r == 16'd8) body_nxt = {b, 8'd0};
          else if (cnt_r == 16'd9) body_nxt = body_r | {8'd0, b};
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_r >= 16'(FIXED_BYTES - 1)) begin
            if (rtype_nxt == TYPE_A) begin
              cnt_nxt   = 16'(V4_BYTES);
              phase_nxt = PH_ADDR;
            end else if (rtype_nxt == TYPE_AAAA) begin
              cnt_nxt   = 16'(V6_BYTES);
              phase_nxt = PH_ADDR;
            end else if (rtype_nxt == TYPE_PTR) begin
              held_valid_nxt = 1'b0;
              started_nxt    = 1'b0;
              held_char_nxt  = 8'd0;
              phase_nxt      = PH_PNAME;
            end else begin
              do_skip = 1'b1;
            end
          end
        end
        PH_ASKIP: begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_nxt == 16'd0) do_rec_done = 1'b1;
        end
        PH_ADDR: begin
          cnt_nxt   = cnt_r - 16'd1;
          emit      = 1'b1;
          emit_kind = (rtype_r == TYPE_A) ? KIND_V4 : KIND_V6;
          emit_byte = b;
          emit_fin  = (cnt_nxt == 16'd0);
        end
        PH_PNAME: begin
          if (body_r != 16'd0) body_nxt = body_r - 16'd1;
          if (q_beat.is_zero) begin
            rev_end = 1'b1;
          end else if (q_beat.is_ptr) begin
            phase_nxt = PH_PPTR;
          end else begin
            label_nxt = b[5:0];
            phase_nxt = PH_PLABEL;
            if (held_valid_r) begin
              emit          = 1'b1;
              emit_kind     = KIND_CHAR;
              emit_byte     = held_char_r;
              held_char_nxt = DOT_CHAR;
            end
          end
        end
        PH_PLABEL: begin
          if (body_r != 16'd0) body_nxt = body_r - 16'd1;
          if (held_valid_r) begin
            emit      = 1'b1;
            emit_kind = KIND_CHAR;
            emit_byte = held_char_r;
          end
          held_char_nxt  = b;
          held_valid_nxt = 1'b1;
          started_nxt    = 1'b1;
          label_nxt      = label_r - 6'd1;
          if (label_nxt == 6'd0) phase_nxt = PH_PNAME;
        end
        PH_PPTR: begin
          if (body_r != 16'd0) body_nxt = body_r - 16'd1;
          rev_end = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // End of a reverse name: release the held character or skip the rest.
      if (rev_end) begin
        if (started_r && held_valid_r) begin
          emit      = 1'b1;
          emit_kind = KIND_CHAR;
          emit_byte = held_char_r;
          emit_fin  = 1'b1;
        end else begin
          do_skip = 1'b1;
        end
      end

      if (do_skip) begin
        if (body_nxt == 16'd0) begin
          do_rec_done = 1'b1;
        end else begin
          cnt_nxt   = body_nxt;
          phase_nxt = PH_ASKIP;
        end
      end

      if (do_rec_done) begin
        ans_nxt = ans_nxt - 16'd1;
        if (ans_nxt == 16'd0) begin
          emit      = 1'b1;
          emit_kind = KIND_NONE;
          emit_byte = 8'd0;
          emit_fin  = 1'b1;
        end else begin
          phase_nxt = PH_ANAME;
        end
      end

      if (emit && emit_fin) begin
        done_nxt  = 1'b1;
        phase_nxt = PH_DONE;
      end

      emit_tag = tag_nxt;

      // Final beat: report truncation if nothing final went out, then rearm.
      if (q_beat.last) begin
        if (!done_nxt) begin
          emit      = 1'b1;
          emit_kind = KIND_TRUNC;
          emit_byte = 8'd0;
          emit_fin  = 1'b1;
        end
        phase_nxt      = PH_HEADER;
        cnt_nxt        = 16'd0;
        tag_nxt        = 16'd0;
        ans_nxt        = 16'd0;
        rtype_nxt      = 16'd0;
        body_nxt       = 16'd0;
        label_nxt      = 6'd0;
        held_char_nxt  = 8'd0;
        held_valid_nxt = 1'b0;
        started_nxt    = 1'b0;
        done_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      cnt_r        <= 16'd0;
      tag_r        <= 16'd0;
      ans_r        <= 16'd0;
      rtype_r      <= 16'd0;
      body_r       <= 16'd0;
      label_r      <= 6'd0;
      held_char_r  <= 8'd0;
      held_valid_r <= 1'b0;
      started_r    <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      tag_r        <= tag_nxt;
      ans_r        <= ans_nxt;
      rtype_r      <= rtype_nxt;
      body_r       <= body_nxt;
      label_r      <= label_nxt;
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      started_r    <= started_nxt;
      done_r       <= done_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_tag_r  <= emit_tag;
      out_kind_r <= emit_kind;
      out_byte_r <= emit_byte;
      out_fin_r  <= emit_fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_query_tag    = out_tag_r;
  assign out_answer_kind  = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_final_result = out_fin_r;

`include "assert_macros.svh"
  `DRA_NEVER(a_held_needs_start, held_valid_r && !started_r, "held character without a name")
  `DRA_ASSERT(a_fin_parks, (advance && emit && emit_fin) |=> (phase_r == PH_DONE || phase_r == PH_HEADER), "final beat did not park the parser")
  `DRA_ASSERT(a_last_rearms, (advance && q_beat.last) |=> (phase_r == PH_HEADER && !done_r), "final byte did not rearm the parser")

endmodule
